// File: src/psuarp_pkg.sv
// Package for the PSU ASCII response parser.
// Character codes, frame kinds, parse phases and shared types.
// No dependencies.
package psuarp_pkg;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_THREE = 8'h33;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_EQUAL = 8'h3D;
   localparam logic [7:0] CHAR_K     = 8'h6B;
   localparam logic [7:0] CHAR_O     = 8'h6F;
   localparam logic [7:0] CHAR_R     = 8'h72;

   localparam logic [3:0] KIND_INVALID  = 4'd0;
   localparam logic [3:0] KIND_WRITE_OK = 4'd1;
   localparam logic [3:0] KIND_MAX_V    = 4'd2;
   localparam logic [3:0] KIND_TEMP     = 4'd7;
   localparam logic [3:0] KIND_OVERFLOW = 4'd8;

   localparam logic [2:0] PH_HEAD   = 3'd0;
   localparam logic [2:0] PH_EQ     = 3'd1;
   localparam logic [2:0] PH_DIGITS = 3'd2;
   localparam logic [2:0] PH_TAIL   = 3'd3;
   localparam logic [2:0] PH_BAD    = 3'd4;

   localparam logic [6:0] ADDR_DEFAULT = 7'd1;
   localparam logic [6:0] ADDR_MAX     = 7'd99;

   localparam int NUM_REGS = 6;

   typedef struct packed {
      logic [3:0] tens;
      logic [3:0] ones;
   } addr_digits_type;

   typedef struct packed {
      logic [3:0]  frame_kind;
      logic [15:0] value;
      logic [15:0] max_voltage;
      logic [15:0] max_current;
      logic [15:0] meas_voltage;
      logic [15:0] meas_current;
      logic [15:0] output_mode;
      logic [15:0] temperature;
   } rsp_payload_type;

endpackage

// File: src/psuarp_ifs.sv
// Channel interfaces of the PSU ASCII response parser: request, response, csr.
// Valid/ready handshake; no dependencies.
interface psuarp_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] rx_byte;
   modport source (output valid, output func, output rx_byte, input ready);
   modport sink (input valid, input func, input rx_byte, output ready);
endinterface

interface psuarp_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  frame_kind;
   logic [15:0] value;
   logic [15:0] max_voltage;
   logic [15:0] max_current;
   logic [15:0] meas_voltage;
   logic [15:0] meas_current;
   logic [15:0] output_mode;
   logic [15:0] temperature;
   modport source (output valid, output frame_kind, output value, output max_voltage,
                   output max_current, output meas_voltage, output meas_current,
                   output output_mode, output temperature, input ready);
   modport sink (input valid, input frame_kind, input value, input max_voltage,
                 input max_current, input meas_voltage, input meas_current,
                 input output_mode, input temperature, output ready);
endinterface

interface psuarp_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] device_address;
   modport source (output valid, output device_address, input ready);
   modport sink (input valid, input device_address, output ready);
endinterface

// File: src/psuarp_core.sv
// Per-byte frame state and judgement of the PSU ASCII response parser.
// Uses psuarp_pkg.
module psuarp_core #(
   parameter int RX_BUFFER_BYTES = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_accept,
   input  logic                      req_func,
   input  logic [7:0]                req_byte,
   input  psuarp_pkg::addr_digits_type addr_digits,
   output logic                      res_valid,
   output psuarp_pkg::rsp_payload_type res_payload
);

   localparam int CNT_W = $clog2(RX_BUFFER_BYTES);
   localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(RX_BUFFER_BYTES - 1);

   logic [CNT_W-1:0] byte_count_ff, byte_count_in;
   logic [2:0]       frame_len_ff, frame_len_in;
   logic [2:0]       phase_ff, phase_in;
   logic             nul_ff, nul_in;
   logic [39:0]      header_ff, header_in;
   logic [15:0]      value_ff, value_in;
   logic [7:0]       flags_ff, flags_in;
   logic [23:0]      recent_ff, recent_in;
   logic [15:0]      regs_ff [psuarp_pkg::NUM_REGS];
   logic [15:0]      regs_in [psuarp_pkg::NUM_REGS];

   logic [7:0]  h4, h3, h2, h1, h0, p1, p2, p3;
   logic        hdr_ok;
   logic [2:0]  hdr_idx;
   logic [3:0]  kind;
   logic [15:0] val;
   logic        is_digit;

   function automatic logic [1:0] bump(input logic [1:0] f);
      bump = {f[1] | f[0], 1'b1};
   endfunction

   assign h4 = header_ff[39:32];
   assign h3 = header_ff[31:24];
   assign h2 = header_ff[23:16];
   assign h1 = header_ff[15:8];
   assign h0 = header_ff[7:0];
   assign p1 = recent_ff[7:0];
   assign p2 = recent_ff[15:8];
   assign p3 = recent_ff[23:16];
   assign is_digit = (req_byte >= psuarp_pkg::CHAR_ZERO) && (req_byte <= psuarp_pkg::CHAR_NINE);

   always_comb begin
      hdr_ok  = 1'b0;
      hdr_idx = 3'd0;
      if (h4 == {4'h3, addr_digits.tens} && h3 == {4'h3, addr_digits.ones}
          && h2 == psuarp_pkg::CHAR_R) begin
         if (h1 == psuarp_pkg::CHAR_ZERO
             && (h0 == psuarp_pkg::CHAR_ZERO || h0 == psuarp_pkg::CHAR_ONE)) begin
            hdr_ok  = 1'b1;
            hdr_idx = {2'b00, h0[0]};
         end else if (h1 == psuarp_pkg::CHAR_THREE && h0 >= psuarp_pkg::CHAR_ZERO
                      && h0 <= psuarp_pkg::CHAR_THREE) begin
            hdr_ok  = 1'b1;
            hdr_idx = {1'b0, h0[1:0]} + 3'd2;
         end
      end
   end

   always_comb begin
      byte_count_in = byte_count_ff;
      frame_len_in  = frame_len_ff;
      phase_in      = phase_ff;
      nul_in        = nul_ff;
      header_in     = header_ff;
      value_in      = value_ff;
      flags_in      = flags_ff;
      recent_in     = recent_ff;
      regs_in       = regs_ff;
      res_valid     = 1'b0;
      kind          = psuarp_pkg::KIND_INVALID;
      val           = 16'd0;
      if (req_accept) begin
         if (req_func || byte_count_ff == LAST_COUNT || req_byte == psuarp_pkg::CHAR_LF) begin
            if (!req_func && byte_count_ff == LAST_COUNT) begin
               res_valid = 1'b1;
               kind      = psuarp_pkg::KIND_OVERFLOW;
            end else if (!req_func) begin
               // closing LF: judge the frame
               res_valid = 1'b1;
               if (!nul_ff && p1 == psuarp_pkg::CHAR_CR && flags_ff[3:2] == 2'd1) begin
                  if (p2 == psuarp_pkg::CHAR_DOT && flags_ff[1:0] == 2'd1) begin
                     if (phase_ff == psuarp_pkg::PH_TAIL && hdr_ok) begin
                        regs_in[hdr_idx] = value_ff;
                        kind = psuarp_pkg::KIND_MAX_V + {1'b0, hdr_idx};
                        val  = value_ff;
                     end
                  end else if (p2 == psuarp_pkg::CHAR_K && p3 == psuarp_pkg::CHAR_O
                               && flags_ff[5:4] == 2'd1 && flags_ff[7:6] == 2'd1) begin
                     kind = psuarp_pkg::KIND_WRITE_OK;
                  end
               end
            end
            byte_count_in = '0;
            phase_in      = psuarp_pkg::PH_HEAD;
            nul_in        = 1'b0;
            frame_len_in  = 3'd0;
            header_in     = 40'd0;
            value_in      = 16'd0;
            flags_in      = 8'd0;
            recent_in     = 24'd0;
         end else begin
            byte_count_in = byte_count_ff + CNT_W'(1);
            if (req_byte == psuarp_pkg::CHAR_COLON) begin
               frame_len_in = 3'd0;
               phase_in     = psuarp_pkg::PH_HEAD;
               header_in    = 40'd0;
               value_in     = 16'd0;
               flags_in     = 8'd0;
               recent_in    = 24'd0;
            end else begin
               if (req_byte == psuarp_pkg::CHAR_NUL)
                  nul_in = 1'b1;
               if (req_byte == psuarp_pkg::CHAR_DOT)
                  flags_in[1:0] = bump(flags_ff[1:0]);
               else if (req_byte == psuarp_pkg::CHAR_CR)
                  flags_in[3:2] = bump(flags_ff[3:2]);
               else if (req_byte == psuarp_pkg::CHAR_O)
                  flags_in[5:4] = bump(flags_ff[5:4]);
               else if (req_byte == psuarp_pkg::CHAR_K)
                  flags_in[7:6] = bump(flags_ff[7:6]);
               case (phase_ff)
                  psuarp_pkg::PH_HEAD: begin
                     if (req_byte == psuarp_pkg::CHAR_EQUAL)
                        phase_in = (frame_len_ff == 3'd5) ? psuarp_pkg::PH_EQ
                                                          : psuarp_pkg::PH_BAD;
                     else if (req_byte == psuarp_pkg::CHAR_DOT)
                        phase_in = psuarp_pkg::PH_BAD;
                     else
                        header_in = {header_ff[31:0], req_byte};
                  end
                  psuarp_pkg::PH_EQ, psuarp_pkg::PH_DIGITS: begin
                     if (is_digit) begin
                        value_in = {value_ff[12:0], 3'b000} + {value_ff[14:0], 1'b0}
                                   + {12'd0, req_byte[3:0]};
                        phase_in = psuarp_pkg::PH_DIGITS;
                     end else if (req_byte == psuarp_pkg::CHAR_DOT
                                  && phase_ff == psuarp_pkg::PH_DIGITS) begin
                        phase_in = psuarp_pkg::PH_TAIL;
                     end else begin
                        phase_in = psuarp_pkg::PH_BAD;
                     end
                  end
                  psuarp_pkg::PH_TAIL: begin
                     if (req_byte == psuarp_pkg::CHAR_EQUAL)
                        phase_in = psuarp_pkg::PH_BAD;
                  end
                  default: phase_in = phase_ff;
               endcase
               recent_in = {recent_ff[15:0], req_byte};
               if (frame_len_ff != 3'd7)
                  frame_len_in = frame_len_ff + 3'd1;
            end
         end
      end
   end

   always_comb begin
      res_payload.frame_kind   = kind;
      res_payload.value        = val;
      res_payload.max_voltage  = regs_in[0];
      res_payload.max_current  = regs_in[1];
      res_payload.meas_voltage = regs_in[2];
      res_payload.meas_current = regs_in[3];
      res_payload.output_mode  = regs_in[4];
      res_payload.temperature  = regs_in[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         frame_len_ff  <= 3'd0;
         phase_ff      <= psuarp_pkg::PH_HEAD;
         nul_ff        <= 1'b0;
         header_ff     <= 40'd0;
         value_ff      <= 16'd0;
         flags_ff      <= 8'd0;
         recent_ff     <= 24'd0;
         for (int i = 0; i < psuarp_pkg::NUM_REGS; i++)
            regs_ff[i] <= 16'd0;
      end else begin
         byte_count_ff <= byte_count_in;
         frame_len_ff  <= frame_len_in;
         phase_ff      <= phase_in;
         nul_ff        <= nul_in;
         header_ff     <= header_in;
         value_ff      <= value_in;
         flags_ff      <= flags_in;
         recent_ff     <= recent_in;
         regs_ff       <= regs_in;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= LAST_COUNT)
      else $error("byte count past buffer end");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_func |=> byte_count_ff == '0 && phase_ff == psuarp_pkg::PH_HEAD
                                 && !nul_ff)
      else $error("clear request did not reset frame");

   a_overflow_at_end: assert property (@(posedge clock) disable iff (reset)
      res_valid && res_payload.frame_kind == psuarp_pkg::KIND_OVERFLOW
      |-> byte_count_ff == LAST_COUNT)
      else $error("overflow before buffer end");
`endif

endmodule

// File: src/psu_ascii_response_parser_top.sv
// Top level of the PSU ASCII response parser: csr, parser core, output buffer.
// Uses psuarp_pkg, psuarp_ifs and psuarp_core.

// The parser takes one received byte per cycle while req_if.ready is high.
// A closing LF, or any byte arriving once the receive buffer count is full,
// yields one response, registered into the output buffer; a clear request
// and all other bytes give none. Responses leave through a two-entry output
// buffer, so req_if.ready drops only while both entries hold responses that
// the sink has not taken. The device address is written through csr_if at
// any time the parser is idle and takes effect from the next request.
module psu_ascii_response_parser_top #(
   parameter int RX_BUFFER_BYTES = 64
) (
   input logic         clock,
   input logic         reset,
   psuarp_req_if.sink  req_if,
   psuarp_rsp_if.source rsp_if,
   psuarp_csr_if.sink  csr_if
);

   psuarp_pkg::addr_digits_type addr_digits_ff, addr_digits_in;
   logic [6:0]  addr_eff;
   logic [14:0] addr_prod;
   logic [6:0]  tens_x10;

   logic        req_accept;
   logic        res_valid;
   psuarp_pkg::rsp_payload_type res_payload;

   logic        out_valid_ff, out_valid_in;
   logic        skid_valid_ff, skid_valid_in;
   psuarp_pkg::rsp_payload_type out_ff, out_in, skid_ff, skid_in;
   logic        pop, push;

   // address to two decimal digits; 205/2048 is exact for 0..99
   always_comb begin
      addr_eff = (csr_if.device_address == 7'd0 || csr_if.device_address > psuarp_pkg::ADDR_MAX)
                 ? psuarp_pkg::ADDR_DEFAULT : csr_if.device_address;
      addr_prod = 15'(addr_eff) * 15'd205;
      addr_digits_in.tens = addr_prod[14:11];
      tens_x10 = {3'b000, addr_digits_in.tens} * 7'd10;
      addr_digits_in.ones = 4'(addr_eff - tens_x10);
   end

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_digits_ff.tens <= 4'd0;
         addr_digits_ff.ones <= 4'd1;
      end else if (csr_if.valid) begin
         addr_digits_ff <= addr_digits_in;
      end
   end

   assign req_if.ready = !skid_valid_ff;
   assign req_accept   = req_if.valid && !skid_valid_ff;

   psuarp_core #(
      .RX_BUFFER_BYTES(RX_BUFFER_BYTES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .req_accept  (req_accept),
      .req_func    (req_if.func),
      .req_byte    (req_if.rx_byte),
      .addr_digits (addr_digits_ff),
      .res_valid   (res_valid),
      .res_payload (res_payload)
   );

   assign push = req_accept && res_valid;
   assign pop  = out_valid_ff && rsp_if.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_in       = res_payload;
         end
      end else if (!out_valid_ff) begin
         out_valid_in = push;
         out_in       = res_payload;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = res_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.frame_kind   = out_ff.frame_kind;
   assign rsp_if.value        = out_ff.value;
   assign rsp_if.max_voltage  = out_ff.max_voltage;
   assign rsp_if.max_current  = out_ff.max_current;
   assign rsp_if.meas_voltage = out_ff.meas_voltage;
   assign rsp_if.meas_current = out_ff.meas_current;
   assign rsp_if.output_mode  = out_ff.output_mode;
   assign rsp_if.temperature  = out_ff.temperature;

`ifndef ASSERT_OFF
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry without head entry");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && (rsp_if.frame_kind < psuarp_pkg::KIND_MAX_V
                       || rsp_if.frame_kind > psuarp_pkg::KIND_TEMP)
      |-> rsp_if.value == 16'd0)
      else $error("nonzero value on non-read response");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      push && out_valid_ff && !rsp_if.ready |=> skid_valid_ff)
      else $error("response lost while head stalled");
`endif

endmodule

// File: verif/psu_ascii_response_parser_top_test.sv
`timescale 1ns / 100ps
// Testbench for psu_ascii_response_parser_top: directed and random reply traffic,
// address writes and response back-pressure, checked against an in-bench predictor.
// Depends on psuarp_pkg, psuarp_ifs and the parser RTL.
module psu_ascii_response_parser_top_test;

   localparam int RX_BYTES    = 64;
   localparam int QUIET_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset;

   psuarp_req_if req_if();
   psuarp_rsp_if rsp_if();
   psuarp_csr_if csr_if();

   psu_ascii_response_parser_top #(.RX_BUFFER_BYTES(RX_BYTES)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always #5 clock = ~clock;

   // parser mirror
   logic [6:0]  addr_cfg;
   logic [6:0]  rx_count;
   logic [6:0]  seg_len;
   logic [2:0]  phase;
   logic        nul_seen;
   logic [39:0] hdr_shift;
   logic [15:0] acc;
   logic [1:0]  dot_n, cr_n, o_n, k_n;
   logic [23:0] last3;
   logic [15:0] psu_regs [psuarp_pkg::NUM_REGS];
   psuarp_pkg::rsp_payload_type expected_replies[$];

   logic [7:0] frame_buf[$];
   string reg_codes[6] = '{"00", "01", "30", "31", "32", "33"};

   int errors = 0;
   int req_taken = 0;
   int csr_taken = 0;
   int quiet_cycles = 0;
   int clears_sent = 0;
   int reads_seen = 0, acks_seen = 0, invalid_seen = 0, overflow_seen = 0;
   bit gaps_on = 1'b0;
   int hold_left = 0;

   function automatic logic [6:0] effective_address();
      return (addr_cfg < 1 || addr_cfg > psuarp_pkg::ADDR_MAX) ? psuarp_pkg::ADDR_DEFAULT
                                                              : addr_cfg;
   endfunction

   function automatic void clear_segment();
      seg_len = '0;
      phase = psuarp_pkg::PH_HEAD;
      hdr_shift = '0;
      acc = '0;
      dot_n = '0; cr_n = '0; o_n = '0; k_n = '0;
      last3 = '0;
   endfunction

   function automatic void clear_frame();
      rx_count = '0;
      nul_seen = 1'b0;
      clear_segment();
   endfunction

   function automatic logic [1:0] bump(logic [1:0] n);
      return (n == 2'd0) ? 2'd1 : 2'd2;
   endfunction

   function automatic int reg_select();
      logic [6:0] a;
      logic [7:0] h1, h0;
      a = effective_address();
      h1 = hdr_shift[15:8];
      h0 = hdr_shift[7:0];
      if (hdr_shift[39:32] != psuarp_pkg::CHAR_ZERO + a / 10 ||
          hdr_shift[31:24] != psuarp_pkg::CHAR_ZERO + a % 10 ||
          hdr_shift[23:16] != psuarp_pkg::CHAR_R)
         return -1;
      if (h1 == psuarp_pkg::CHAR_ZERO &&
          (h0 == psuarp_pkg::CHAR_ZERO || h0 == psuarp_pkg::CHAR_ONE))
         return int'(h0 - psuarp_pkg::CHAR_ZERO);
      if (h1 == psuarp_pkg::CHAR_THREE && h0 >= psuarp_pkg::CHAR_ZERO &&
          h0 <= psuarp_pkg::CHAR_THREE)
         return int'(h0 - psuarp_pkg::CHAR_ZERO) + 2;
      return -1;
   endfunction

   function automatic void push_reply(logic [3:0] kind, logic [15:0] val);
      psuarp_pkg::rsp_payload_type r;
      r.frame_kind   = kind;
      r.value        = val;
      r.max_voltage  = psu_regs[0];
      r.max_current  = psu_regs[1];
      r.meas_voltage = psu_regs[2];
      r.meas_current = psu_regs[3];
      r.output_mode  = psu_regs[4];
      r.temperature  = psu_regs[5];
      expected_replies.push_back(r);
   endfunction

   function automatic void reset_parser_mirror();
      addr_cfg = psuarp_pkg::ADDR_DEFAULT;
      for (int i = 0; i < psuarp_pkg::NUM_REGS; i++) psu_regs[i] = '0;
      clear_frame();
   endfunction

   function automatic void parse_rx_byte(logic f, logic [7:0] b);
      int idx;
      logic [3:0] kind;
      logic [15:0] val;
      if (f) begin
         clear_frame();
         return;
      end
      if (rx_count >= RX_BYTES - 1) begin
         push_reply(psuarp_pkg::KIND_OVERFLOW, '0);
         clear_frame();
         return;
      end
      rx_count++;
      if (b == psuarp_pkg::CHAR_LF) begin
         kind = psuarp_pkg::KIND_INVALID;
         val = '0;
         if (!nul_seen && last3[7:0] == psuarp_pkg::CHAR_CR && cr_n == 2'd1) begin
            if (last3[15:8] == psuarp_pkg::CHAR_DOT && dot_n == 2'd1) begin
               if (phase == psuarp_pkg::PH_TAIL) begin
                  idx = reg_select();
                  if (idx >= 0) begin
                     psu_regs[idx] = acc;
                     kind = 4'(psuarp_pkg::KIND_MAX_V + idx);
                     val = acc;
                  end
               end
            end else if (last3[15:8] == psuarp_pkg::CHAR_K &&
                         last3[23:16] == psuarp_pkg::CHAR_O &&
                         o_n == 2'd1 && k_n == 2'd1) begin
               kind = psuarp_pkg::KIND_WRITE_OK;
            end
         end
         push_reply(kind, val);
         clear_frame();
         return;
      end
      if (b == psuarp_pkg::CHAR_COLON) begin
         clear_segment();
         return;
      end
      if (b == psuarp_pkg::CHAR_NUL) nul_seen = 1'b1;
      case (b)
         psuarp_pkg::CHAR_DOT: dot_n = bump(dot_n);
         psuarp_pkg::CHAR_CR:  cr_n  = bump(cr_n);
         psuarp_pkg::CHAR_O:   o_n   = bump(o_n);
         psuarp_pkg::CHAR_K:   k_n   = bump(k_n);
         default: ;
      endcase
      case (phase)
         psuarp_pkg::PH_HEAD: begin
            if (b == psuarp_pkg::CHAR_EQUAL)
               phase = (seg_len == 7'd5) ? psuarp_pkg::PH_EQ : psuarp_pkg::PH_BAD;
            else if (b == psuarp_pkg::CHAR_DOT) phase = psuarp_pkg::PH_BAD;
            else hdr_shift = {hdr_shift[31:0], b};
         end
         psuarp_pkg::PH_EQ, psuarp_pkg::PH_DIGITS: begin
            if (b >= psuarp_pkg::CHAR_ZERO && b <= psuarp_pkg::CHAR_NINE) begin
               acc = 16'(acc * 10 + (b - psuarp_pkg::CHAR_ZERO));
               phase = psuarp_pkg::PH_DIGITS;
            end else if (b == psuarp_pkg::CHAR_DOT) begin
               phase = (phase == psuarp_pkg::PH_DIGITS) ? psuarp_pkg::PH_TAIL
                                                        : psuarp_pkg::PH_BAD;
            end else begin
               phase = psuarp_pkg::PH_BAD;
            end
         end
         psuarp_pkg::PH_TAIL: begin
            if (b == psuarp_pkg::CHAR_EQUAL) phase = psuarp_pkg::PH_BAD;
         end
         default: ;
      endcase
      last3 = {last3[15:0], b};
      if (seg_len < 7'd127) seg_len++;
   endfunction

   task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   task automatic check_reply();
      psuarp_pkg::rsp_payload_type want;
      if (expected_replies.size() == 0) begin
         $display("%0t: unexpected response, kind %0d value %0d", $time,
                  rsp_if.frame_kind, rsp_if.value);
         errors++;
         return;
      end
      want = expected_replies.pop_front();
      compare_field("frame_kind", 16'(want.frame_kind), 16'(rsp_if.frame_kind));
      compare_field("value", want.value, rsp_if.value);
      compare_field("max_voltage", want.max_voltage, rsp_if.max_voltage);
      compare_field("max_current", want.max_current, rsp_if.max_current);
      compare_field("meas_voltage", want.meas_voltage, rsp_if.meas_voltage);
      compare_field("meas_current", want.meas_current, rsp_if.meas_current);
      compare_field("output_mode", want.output_mode, rsp_if.output_mode);
      compare_field("temperature", want.temperature, rsp_if.temperature);
      if (want.frame_kind == psuarp_pkg::KIND_OVERFLOW) overflow_seen++;
      else if (want.frame_kind == psuarp_pkg::KIND_WRITE_OK) acks_seen++;
      else if (want.frame_kind == psuarp_pkg::KIND_INVALID) invalid_seen++;
      else reads_seen++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (rsp_if.valid && rsp_if.ready) begin
            check_reply();
            quiet_cycles = 0;
         end
         if (req_if.valid && req_if.ready) begin
            parse_rx_byte(req_if.func, req_if.rx_byte);
            req_taken++;
            quiet_cycles = 0;
         end
         if (csr_if.valid && csr_if.ready) begin
            addr_cfg = csr_if.device_address;
            csr_taken++;
            quiet_cycles = 0;
         end
      end
   end

   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready = 1'b0;
      end else begin
         rsp_if.ready = !(gaps_on && $urandom_range(99) < 36);
      end
   end

   task automatic send_req(logic f, logic [7:0] b);
      int n;
      if (gaps_on) begin
         while ($urandom_range(99) < 36) begin
            req_if.valid = 1'b0;
            @(negedge clock);
         end
      end
      n = req_taken;
      req_if.valid = 1'b1;
      req_if.func = f;
      req_if.rx_byte = b;
      while (req_taken == n) @(negedge clock);
      req_if.valid = 1'b0;
   endtask

   task automatic send_clear();
      send_req(1'b1, 8'($urandom_range(255)));
      clears_sent++;
   endtask

   task automatic send_frame();
      while (frame_buf.size() != 0) send_req(1'b0, frame_buf.pop_front());
   endtask

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) frame_buf.push_back(s[i]);
   endfunction

   function automatic void add_crlf();
      frame_buf.push_back(psuarp_pkg::CHAR_CR);
      frame_buf.push_back(psuarp_pkg::CHAR_LF);
   endfunction

   function automatic void add_read(int a, string code, int v);
      add_text($sformatf(":%02dr%s=%0d", a, code, v));
      frame_buf.push_back(psuarp_pkg::CHAR_DOT);
      add_crlf();
   endfunction

   function automatic void add_ack();
      add_text(":ok");
      add_crlf();
   endfunction

   function automatic logic [7:0] rand_byte_no_lf();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      return (b == psuarp_pkg::CHAR_LF) ? psuarp_pkg::CHAR_NUL : b;
   endfunction

   task automatic wait_drained();
      while (expected_replies.size() != 0) @(negedge clock);
   endtask

   task automatic write_address(logic [6:0] a);
      int n;
      wait_drained();
      repeat (4) @(negedge clock);
      n = csr_taken;
      csr_if.valid = 1'b1;
      csr_if.device_address = a;
      while (csr_taken == n) @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   task automatic test_directed_replies();
      add_text("ok"); add_crlf();
      add_ack();
      add_read(1, "00", 0);
      add_read(1, "01", 65535);
      add_read(1, "30", 65536);
      add_read(1, "31", 12345);
      add_read(1, "32", 99999);
      add_read(1, "33", 7);
      add_text("junk"); add_read(1, "30", 42);
      add_text("01r31=5."); add_crlf();
      add_text(":01r00=12.="); add_crlf();
      add_text(":01r00==3."); add_crlf();
      add_text(":01r01="); frame_buf.push_back(psuarp_pkg::CHAR_NUL); add_text("4."); add_crlf();
      add_text(":1r00=5."); add_crlf();
      add_text(":001r00=5."); add_crlf();
      add_text(":01r00=."); add_crlf();
      add_text(":01r00=1a2."); add_crlf();
      add_read(1, "02", 5);
      add_read(1, "34", 5);
      add_read(2, "00", 5);
      add_text(":01r00=5.."); add_crlf();
      add_text("okok"); add_crlf();
      frame_buf.push_back(8'hFF); frame_buf.push_back(8'h80); add_ack();
      send_frame();
      add_text(":01r00=9");
      send_frame();
      send_clear();
      add_read(1, "01", 3);
      send_frame();
      // full buffer: the closing LF lands on the overflow slot
      repeat (RX_BYTES - 1) frame_buf.push_back("x");
      frame_buf.push_back(psuarp_pkg::CHAR_LF);
      repeat (RX_BYTES - 1) frame_buf.push_back("y");
      frame_buf.push_back("z");
      add_read(1, "33", 300);
      frame_buf.push_back(psuarp_pkg::CHAR_LF);
      add_crlf();
      send_frame();
      send_req(1'b1, 8'hFF);
      send_req(1'b1, 8'h00);
      clears_sent += 2;
   endtask

   task automatic test_device_address();
      logic [6:0] addr_list[6] = '{psuarp_pkg::ADDR_MAX, 7'd0, 7'd127, 7'd100, 7'd10,
                                   psuarp_pkg::ADDR_DEFAULT};
      foreach (addr_list[i]) begin
         write_address(addr_list[i]);
         add_read(effective_address(), "00", $urandom_range(65535));
         add_read(addr_list[i], "31", $urandom_range(65535));
         add_read(effective_address() % 99 + 1, "33", $urandom_range(65535));
         add_read(effective_address(), "32", $urandom_range(65535));
         send_frame();
      end
   endtask

   task automatic test_backpressure();
      gaps_on = 1'b0;
      wait_drained();
      hold_left = 100;
      repeat (12) add_ack();
      send_frame();
      wait_drained();
   endtask

   task automatic send_random_replies(int n_bytes);
      int start, pick, cut, v, a;
      string code;
      start = req_taken;
      while (req_taken - start < n_bytes) begin
         pick = $urandom_range(99);
         if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 5)) frame_buf.push_back(rand_byte_no_lf());
         if (pick < 74) begin
            if (pick < 62) begin
               case ($urandom_range(3))
                  0: v = $urandom_range(9);
                  1: v = $urandom_range(65535);
                  2: v = $urandom_range(9999999, 65536);
                  default: v = 65535 + $urandom_range(1);
               endcase
               code = ($urandom_range(7) == 0) ? $sformatf("%02d", $urandom_range(99))
                                               : reg_codes[$urandom_range(5)];
               a = ($urandom_range(7) == 0) ? $urandom_range(120) : effective_address();
               add_read(a, code, v);
            end else begin
               add_ack();
            end
            if ($urandom_range(6) == 0)
               frame_buf[$urandom_range(frame_buf.size() - 1)] = 8'($urandom_range(255));
            else if ($urandom_range(9) == 0)
               frame_buf.insert($urandom_range(frame_buf.size() - 1), psuarp_pkg::CHAR_EQUAL);
            send_frame();
         end else if (pick < 88) begin
            repeat ($urandom_range(1, 20)) frame_buf.push_back(8'($urandom_range(255)));
            if ($urandom_range(3) != 0) frame_buf.push_back(psuarp_pkg::CHAR_LF);
            send_frame();
         end else if (pick < 95) begin
            add_read(effective_address(), reg_codes[$urandom_range(5)], $urandom_range(65535));
            cut = $urandom_range(frame_buf.size() - 1);
            while (frame_buf.size() > cut) void'(frame_buf.pop_back());
            send_frame();
            send_clear();
         end else begin
            repeat ($urandom_range(55, 75)) frame_buf.push_back(rand_byte_no_lf());
            frame_buf.push_back(psuarp_pkg::CHAR_LF);
            send_frame();
         end
      end
   endtask

   task automatic test_random_traffic();
      gaps_on = 1'b1;
      write_address(7'($urandom_range(psuarp_pkg::ADDR_MAX, 1)));
      send_random_replies(30);
      gaps_on = 1'b0;
      send_random_replies(30);
      gaps_on = 1'b1;
      write_address(psuarp_pkg::ADDR_MAX);
      send_random_replies(30);
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.func = 1'b0;
      req_if.rx_byte = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.device_address = psuarp_pkg::ADDR_DEFAULT;
      reset_parser_mirror();
      repeat (4) @(negedge clock);
      reset = 1'b0;
      test_directed_replies();
      test_device_address();
      test_backpressure();
      test_random_traffic();
      wait_drained();
      repeat (10) @(negedge clock);
      $display("Sent %0d requests (%0d clears) and %0d address writes.",
               req_taken, clears_sent, csr_taken);
      $display("Checked %0d reads, %0d write acks, %0d invalid and %0d overflow responses.",
               reads_seen, acks_seen, invalid_seen, overflow_seen);
      if (errors == 0 && expected_replies.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
